### hw/rtl/gchs_pkg.sv
// ----------------------------------------------------------------------------
// gchs_pkg
// Shared types, constants and helpers for the grid cell hash set.
// ----------------------------------------------------------------------------
package gchs_pkg;

	localparam int TABLE_SLOTS = 4096;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int COORD_W     = 21;
	localparam int KEY_W       = 3 * COORD_W;
	localparam int WORD_W      = 64;
	localparam int HALF_W      = WORD_W / 2;
	localparam int LIMIT_W     = 13;
	localparam int SLOT_OUT_W  = 12;
	localparam int MIX_SHIFT   = 33;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3072);

	localparam logic [WORD_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [WORD_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [LIMIT_W-1:0] count_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_M0,
		H_M1,
		H_M2,
		H_M3,
		H_XS
	} hash_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_HASH,
		S_READ,
		S_CHECK
	} set_state_t;

	function automatic word_t xor_shift(input word_t v);
		return v ^ (v >> MIX_SHIFT);
	endfunction

endpackage

### hw/rtl/gchs_hash.sv
// ----------------------------------------------------------------------------
// gchs_hash
// Finalizer hash of a packed cell key on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module gchs_hash (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gchs_pkg::key_t  key,
	output logic            done,
	output gchs_pkg::word_t hash
);
	import gchs_pkg::*;

	hash_state_t state_q;
	hash_state_t state_d;
	logic        round_q;
	logic        done_q;
	word_t       v_q;
	word_t       acc_q;
	word_t       prod_q;
	word_t       c_sel;
	word_t       mul_p;
	logic [HALF_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;

	assign c_sel = round_q ? MIX_C2 : MIX_C1;
	assign mul_p = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
	assign done  = done_q;
	assign hash  = v_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			H_IDLE: if (start) state_d = H_M0;
			H_M0:   state_d = H_M1;
			H_M1:   state_d = H_M2;
			H_M2:   state_d = H_M3;
			H_M3:   state_d = H_XS;
			H_XS:   state_d = round_q ? H_IDLE : H_M0;
			default: state_d = H_IDLE;
		endcase
	end

	// low x low, low x high, high x low; high x high falls outside 64 bits
	always_comb begin
		mul_a = v_q[HALF_W-1:0];
		mul_b = c_sel[HALF_W-1:0];
		unique case (state_q)
			H_M1: begin
				mul_b = c_sel[WORD_W-1:HALF_W];
			end
			H_M2: begin
				mul_a = v_q[WORD_W-1:HALF_W];
			end
			default: begin
				mul_a = v_q[HALF_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			round_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == H_XS) && round_q;
			if (state_q == H_IDLE) begin
				round_q <= 1'b0;
			end else if (state_q == H_XS) begin
				round_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			H_IDLE: begin
				if (start) v_q <= xor_shift(WORD_W'(key));
			end
			H_M0: begin
				prod_q <= mul_p;
			end
			H_M1: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			H_M2: begin
				acc_q[WORD_W-1:HALF_W] <= acc_q[WORD_W-1:HALF_W] + prod_q[HALF_W-1:0];
				prod_q <= mul_p;
			end
			H_M3: begin
				acc_q[WORD_W-1:HALF_W] <= acc_q[WORD_W-1:HALF_W] + prod_q[HALF_W-1:0];
			end
			H_XS: begin
				v_q <= xor_shift(acc_q);
			end
			default: begin
				v_q <= v_q;
			end
		endcase
	end

endmodule

### hw/rtl/grid_cell_hash_set.sv
// Insert: the key is hashed on one shared multiplier, then each probed slot is read
// from the registered table and checked; done follows the last check.
// Clear: one table slot swept per cycle; busy is high meanwhile.
// After reset a clearing pass over every slot runs with busy high and no result.
// A new request is taken in the cycle its predecessor's done is shown.
// Each result is shown for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// grid_cell_hash_set
// Fixed-capacity linear probing set of packed 3-D grid cell keys.
// ----------------------------------------------------------------------------
module grid_cell_hash_set (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic [gchs_pkg::COORD_W-1:0]    cell_x,
	input  logic [gchs_pkg::COORD_W-1:0]    cell_y,
	input  logic [gchs_pkg::COORD_W-1:0]    cell_z,
	output logic                            done,
	output logic                            newly_added,
	output logic                            table_full,
	output logic [gchs_pkg::SLOT_OUT_W-1:0] slot_index,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gchs_pkg::LIMIT_W-1:0]    cfg_data
);
	import gchs_pkg::*;

	set_state_t state_q;
	set_state_t state_d;

	key_t   key_q;
	key_t   in_key;
	slot_t  pos_q;
	slot_t  probes_q;
	slot_t  clr_addr_q;
	logic   clr_reply_q;
	count_t count_q;
	count_t limit_q;

	logic   done_q;
	logic   newly_added_q;
	logic   table_full_q;
	logic [SLOT_OUT_W-1:0] slot_index_q;

	word_t  mem [TABLE_SLOTS];
	word_t  rdata_q;
	logic   mem_we;
	slot_t  mem_waddr;
	word_t  mem_wdata;

	logic   accept;
	logic   hash_start;
	logic   hash_done;
	word_t  hash_val;

	logic   slot_empty;
	logic   key_hit;
	logic   at_limit;
	logic   last_probe;
	logic   clr_last;

	assign in_key     = {cell_x, cell_y, cell_z};
	assign accept     = start && !busy;
	assign hash_start = accept && (req_type == REQ_INSERT);
	assign slot_empty = !rdata_q[WORD_W-1];
	assign key_hit    = rdata_q[KEY_W-1:0] == key_q;
	assign at_limit   = count_q >= limit_q;
	assign last_probe = probes_q == {SLOT_W{1'b1}};
	assign clr_last   = clr_addr_q == {SLOT_W{1'b1}};

	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign newly_added = newly_added_q;
	assign table_full  = table_full_q;
	assign slot_index  = slot_index_q;

	gchs_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (in_key),
		.done   (hash_done),
		.hash   (hash_val)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = (req_type == REQ_CLEAR) ? S_CLEAR : S_HASH;
			end
			S_CLEAR: begin
				if (clr_last) state_d = S_IDLE;
			end
			S_HASH: begin
				if (hash_done) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				priority if (slot_empty || key_hit || last_probe) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_READ;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy      = state_q != S_IDLE;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = {1'b1, key_q};
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			S_CHECK: begin
				mem_we = slot_empty && !at_limit;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			clr_reply_q <= 1'b0;
			count_q     <= '0;
			limit_q     <= LIMIT_RESET;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) limit_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (accept && (req_type == REQ_CLEAR)) begin
						clr_addr_q  <= '0;
						clr_reply_q <= 1'b1;
						count_q     <= '0;
					end
				end
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					done_q     <= clr_last && clr_reply_q;
				end
				S_CHECK: begin
					done_q <= slot_empty || key_hit || last_probe;
					if (slot_empty && !at_limit) count_q <= count_q + 1'b1;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) key_q <= in_key;
			end
			S_CLEAR: begin
				newly_added_q <= 1'b0;
				table_full_q  <= 1'b0;
				slot_index_q  <= '0;
			end
			S_HASH: begin
				pos_q    <= hash_val[SLOT_W-1:0];
				probes_q <= '0;
			end
			S_CHECK: begin
				priority if (slot_empty) begin
					newly_added_q <= !at_limit;
					table_full_q  <= at_limit;
					slot_index_q  <= at_limit ? '0 : SLOT_OUT_W'(pos_q);
				end else if (key_hit) begin
					newly_added_q <= 1'b0;
					table_full_q  <= 1'b0;
					slot_index_q  <= SLOT_OUT_W'(pos_q);
				end else if (last_probe) begin
					newly_added_q <= 1'b0;
					table_full_q  <= 1'b1;
					slot_index_q  <= '0;
				end else begin
					pos_q    <= pos_q + 1'b1;
					probes_q <= probes_q + 1'b1;
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_hash_set testbench
// Drives insert and clear requests through the start/busy port and checks every
// done strobe against a behavioral copy of the hash set. Probe chains across the
// wrap point are built from keys chosen by inverting the hash. The occupancy
// limit is changed between phases and sender gaps vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
	import gchs_pkg::*;

	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int BLOCK_ITEMS  = 200;
	localparam int BLOCK_COUNT  = 8;
	localparam int POOL_DEPTH   = 48;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic                  newly;
		logic                  full;
		logic [SLOT_OUT_W-1:0] slot;
	} outcome_t;

	class cell_set_model;
		key_t       stored_keys[TABLE_SLOTS];
		bit         slot_used[TABLE_SLOTS];
		count_t     key_count;
		count_t     limit;
		outcome_t   pending_outcomes[$];
		int         errors;
		int         n_added;
		int         n_dup;
		int         n_refused;
		int         n_clear;

		function new();
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			key_count = '0;
			limit     = LIMIT_RESET;
			errors    = 0;
			n_added   = 0;
			n_dup     = 0;
			n_refused = 0;
			n_clear   = 0;
		endfunction

		function word_t mix(word_t v);
			v = v ^ (v >> MIX_SHIFT);
			v = v * MIX_C1;
			v = v ^ (v >> MIX_SHIFT);
			v = v * MIX_C2;
			v = v ^ (v >> MIX_SHIFT);
			return v;
		endfunction

		function void set_limit(count_t v);
			limit = v;
		endfunction

		function int outstanding();
			return pending_outcomes.size();
		endfunction

		function void take_request(logic req, coord_t x, coord_t y, coord_t z);
			key_t     k;
			word_t    h;
			slot_t    pos;
			bit       found;
			bit       have_empty;
			outcome_t o;
			o = '0;
			if (req == REQ_CLEAR) begin
				foreach (slot_used[i]) slot_used[i] = 1'b0;
				key_count = '0;
				n_clear++;
			end else begin
				k = {x, y, z};
				h = mix(word_t'(k));
				pos = h[SLOT_W-1:0];
				found = 1'b0;
				have_empty = 1'b0;
				for (int n = 0; n < TABLE_SLOTS; n++) begin
					if (!slot_used[pos]) begin
						have_empty = 1'b1;
						break;
					end
					if (stored_keys[pos] == k) begin
						found = 1'b1;
						break;
					end
					pos = pos + 1'b1;
				end
				if (found) begin
					o.slot = SLOT_OUT_W'(pos);
					n_dup++;
				end else if (!have_empty || key_count >= limit) begin
					o.full = 1'b1;
					n_refused++;
				end else begin
					stored_keys[pos] = k;
					slot_used[pos] = 1'b1;
					key_count = key_count + 1'b1;
					o.newly = 1'b1;
					o.slot = SLOT_OUT_W'(pos);
					n_added++;
				end
			end
			pending_outcomes = {pending_outcomes, o};
		endfunction

		function void check_response(logic newly, logic full, logic [SLOT_OUT_W-1:0] slot);
			outcome_t o;
			if (pending_outcomes.size() == 0) begin
				$display("%0t unexpected result: newly_added %0d table_full %0d slot_index %0d",
					$time, newly, full, slot);
				errors++;
				return;
			end
			o = pending_outcomes.pop_front();
			if (newly !== o.newly) begin
				$display("%0t newly_added mismatch: expected %0d actual %0d",
					$time, o.newly, newly);
				errors++;
			end
			if (full !== o.full) begin
				$display("%0t table_full mismatch: expected %0d actual %0d",
					$time, o.full, full);
				errors++;
			end
			if (slot !== o.slot) begin
				$display("%0t slot_index mismatch: expected %0d actual %0d",
					$time, o.slot, slot);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	logic                  req_type  = REQ_INSERT;
	coord_t                cell_x    = '0;
	coord_t                cell_y    = '0;
	coord_t                cell_z    = '0;
	logic                  done;
	logic                  newly_added;
	logic                  table_full;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	count_t                cfg_data  = '0;

	cell_set_model model;
	int            cycle_count = 0;
	key_t          recent_keys[$];

	grid_cell_hash_set dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_z      (cell_z),
		.done        (done),
		.newly_added (newly_added),
		.table_full  (table_full),
		.slot_index  (slot_index),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL grid_cell_hash_set");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) model.check_response(newly_added, table_full, slot_index);
	end

	function automatic word_t odd_inverse(word_t a);
		word_t x;
		x = a;
		repeat (6) x = x * (64'd2 - a * x);
		return x;
	endfunction

	function automatic word_t unmix(word_t h);
		word_t v;
		v = h ^ (h >> MIX_SHIFT);
		v = v * odd_inverse(MIX_C2);
		v = v ^ (v >> MIX_SHIFT);
		v = v * odd_inverse(MIX_C1);
		v = v ^ (v >> MIX_SHIFT);
		return v;
	endfunction

	// key whose home slot is s, random otherwise
	function automatic key_t key_for_slot(slot_t s);
		word_t v;
		v = '1;
		while (v[WORD_W-1]) v = unmix({32'($urandom), 20'($urandom), s});
		return v[KEY_W-1:0];
	endfunction

	function automatic coord_t edge_coord();
		case ($urandom_range(2))
			0: return '0;
			1: return '1;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic send_request(logic req, coord_t x, coord_t y, coord_t z);
		start    <= 1'b1;
		req_type <= req;
		cell_x   <= x;
		cell_y   <= y;
		cell_z   <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		model.take_request(req, x, y, z);
	endtask

	task automatic send_key(key_t k);
		send_request(REQ_INSERT, k[KEY_W-1:2*COORD_W], k[2*COORD_W-1:COORD_W], k[COORD_W-1:0]);
	endtask

	task automatic send_clear();
		send_request(REQ_CLEAR, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
	endtask

	task automatic drain();
		if (model.outstanding() != 0) begin
			start <= 1'b0;
			while (model.outstanding() != 0) @(posedge clk);
		end
	endtask

	task automatic sender_gap(int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	endtask

	task automatic write_limit(count_t v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model.set_limit(v);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		key_t   k;
		key_t   wrap_keys[3];
		count_t block_limits[BLOCK_COUNT];
		slot_t  wrap_slots[3];
		slot_t  block_hot;
		int     item_no;
		int     pct;
		int     r;

		model = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, duplicates, probing across the wrap point
		send_request(REQ_INSERT, '0, '0, '0);
		send_request(REQ_INSERT, '1, '1, '1);
		send_request(REQ_INSERT, '1, '1, '1);
		foreach (wrap_keys[i]) begin
			wrap_keys[i] = key_for_slot(slot_t'(TABLE_SLOTS - 1));
			send_key(wrap_keys[i]);
		end
		send_key(wrap_keys[2]);
		send_request(REQ_INSERT, '1, '0, '0);
		send_request(REQ_INSERT, '0, '1, '0);
		send_request(REQ_INSERT, '0, '0, '1);
		send_request(REQ_CLEAR, '1, '1, '1);
		send_request(REQ_INSERT, '1, '1, '1);

		// limit reached: duplicates still found, absent keys refused
		write_limit(count_t'(1));
		send_request(REQ_INSERT, '0, '0, '0);
		send_request(REQ_INSERT, '1, '1, '1);
		send_request(REQ_CLEAR, '0, '0, '0);
		send_request(REQ_INSERT, '0, '0, '0);
		send_request(REQ_INSERT, '0, '0, '1);
		write_limit(count_t'(0));
		send_request(REQ_INSERT, '1, '0, '1);
		send_request(REQ_INSERT, '0, '0, '0);

		block_limits = '{count_t'(TABLE_SLOTS), count_t'(1), '1, count_t'(0),
			count_t'($urandom_range(2, 48)), LIMIT_RESET,
			count_t'($urandom_range(1, TABLE_SLOTS)), count_t'($urandom_range(2, 48))};
		wrap_slots = '{slot_t'(TABLE_SLOTS - 2), slot_t'(TABLE_SLOTS - 1), slot_t'(0)};
		item_no = 0;
		for (int b = 0; b < BLOCK_COUNT; b++) begin
			write_limit(block_limits[b]);
			block_hot = slot_t'($urandom);
			for (int i = 0; i < BLOCK_ITEMS; i++) begin
				pct = (item_no < 533) ? 19 : (item_no < 1066) ? 51 : 0;
				if ($urandom_range(99) == 0) drain();
				else sender_gap(pct);
				r = $urandom_range(99);
				if (r < 3) begin
					send_clear();
				end else begin
					if (r < 38 && recent_keys.size() != 0)
						k = recent_keys[$urandom_range(recent_keys.size() - 1)];
					else if (r < 60)
						k = key_for_slot($urandom_range(1) ? wrap_slots[$urandom_range(2)]
							: block_hot);
					else if (r < 66)
						k = {edge_coord(), edge_coord(), edge_coord()};
					else
						k = KEY_W'({$urandom, $urandom});
					send_key(k);
					recent_keys = {recent_keys, k};
					if (recent_keys.size() > POOL_DEPTH) void'(recent_keys.pop_front());
				end
				item_no++;
			end
		end

		drain();
		start <= 1'b0;
		repeat (40) @(posedge clk);

		$display("requests: %0d new keys, %0d duplicates, %0d refused, %0d clears",
			model.n_added, model.n_dup, model.n_refused, model.n_clear);
		$display("limits 0, 1, 4096, 8191 and random values; probe chains across the wrap point");
		if (model.errors == 0 && model.outstanding() == 0) begin
			$display("PASS grid_cell_hash_set");
		end else begin
			$display("FAIL grid_cell_hash_set");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/gchs_pkg.sv
hw/rtl/gchs_hash.sv
hw/rtl/grid_cell_hash_set.sv
tb/sv/testbench.sv
